FILE: rtl/core/psbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psbf_pkg: shared types and constants of the PNG stored-block framer
// Byte layout of one transaction run, CRC-32 and clamp helpers.
// ----------------------------------------------------------------------------
package psbf_pkg;

    localparam int MAX_WIDTH       = 21844;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    localparam logic [63:0] PNG_SIG   = 64'h89504e470d0a1a0a;
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454e44;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;
    localparam logic [7:0]  BIT_DEPTH = 8'd8;
    localparam logic [7:0]  COLOR_RGB = 8'd2;

    // register byte addresses (bit 2 selects the register)
    localparam logic [2:0]  ADDR_WIDTH  = 3'd0;
    localparam logic [2:0]  ADDR_HEIGHT = 3'd4;

    typedef logic [6:0] pos_t;

    // position of each byte within the longest possible run
    localparam pos_t POS_SIG       = 7'd0;
    localparam pos_t POS_IHDR_LEN  = 7'd8;
    localparam pos_t POS_IHDR_TYPE = 7'd12;
    localparam pos_t POS_IMG_W     = 7'd16;
    localparam pos_t POS_IMG_H     = 7'd20;
    localparam pos_t POS_DEPTH     = 7'd24;
    localparam pos_t POS_COLOR     = 7'd25;
    localparam pos_t POS_IHDR_CRC  = 7'd29;
    localparam pos_t POS_IDAT_LEN  = 7'd33;
    localparam pos_t POS_IDAT_TYPE = 7'd37;
    localparam pos_t POS_ZLIB      = 7'd41;
    localparam pos_t POS_BLK       = 7'd43;
    localparam pos_t POS_FILTER    = 7'd48;
    localparam pos_t POS_PIX       = 7'd49;
    localparam pos_t POS_ADLER     = 7'd50;
    localparam pos_t POS_IDAT_CRC  = 7'd54;
    localparam pos_t POS_IEND_LEN  = 7'd58;
    localparam pos_t POS_IEND_TYPE = 7'd62;
    localparam pos_t POS_IEND_CRC  = 7'd66;
    localparam pos_t POS_END       = 7'd69;

    typedef struct packed {
        logic [7:0] pix;
        logic       hdr;        // first byte of a file: header goes first
        logic       row_start;  // block header and filter byte go first
        logic       last_row;   // BFINAL of this row
        logic       file_end;   // trailer goes after the pixel
    } psbf_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [14:0] clamp_width(input logic [14:0] w);
        logic [14:0] r;
        r = w;
        if (w == 15'd0)
        begin
            r = 15'd1;
        end
        else if (w > 15'(MAX_WIDTH))
        begin
            r = 15'(MAX_WIDTH);
        end
        return r;
    endfunction

    function automatic logic [14:0] clamp_height(input logic [14:0] h);
        return (h == 15'd0) ? 15'd1 : h;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/psbf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psbf_front: input side of the framer
// Accepts pixel bytes, tracks row and file position, tags each item.
// ----------------------------------------------------------------------------
module psbf_front
    import psbf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pixel_valid,
    output      logic        pixel_ready,
    input  wire logic [7:0]  pixel_byte,
    input  wire logic [14:0] img_width,
    input  wire logic [14:0] img_height,
    input  wire logic        queue_full,
    output      logic        push,
    output      psbf_item_t  item
);

    logic        header_sent_reg, header_sent_next;
    logic [15:0] byte_in_row_reg, byte_in_row_next;
    logic [14:0] row_index_reg, row_index_next;

    logic [15:0] row_bytes;
    logic [15:0] bin_inc;
    logic        row_end;
    logic        last_row;

    assign pixel_ready = !queue_full;
    assign push        = pixel_valid && pixel_ready;

    always_comb
    begin
        row_bytes = {img_width, 1'b0} + {1'b0, img_width};
        bin_inc   = byte_in_row_reg + 16'd1;
        row_end   = bin_inc >= row_bytes;
        last_row  = ({1'b0, row_index_reg} + 16'd1) >= {1'b0, img_height};

        item.pix       = pixel_byte;
        item.hdr       = !header_sent_reg;
        item.row_start = byte_in_row_reg == 16'd0;
        item.last_row  = last_row;
        item.file_end  = row_end && last_row;

        header_sent_next = header_sent_reg;
        byte_in_row_next = byte_in_row_reg;
        row_index_next   = row_index_reg;
        if (push)
        begin
            header_sent_next = 1'b1;
            byte_in_row_next = bin_inc;
            if (row_end && last_row)
            begin
                header_sent_next = 1'b0;
                byte_in_row_next = 16'd0;
                row_index_next   = 15'd0;
            end
            else if (row_end)
            begin
                byte_in_row_next = 16'd0;
                row_index_next   = row_index_reg + 15'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_sent_reg <= 1'b0;
            byte_in_row_reg <= 16'd0;
            row_index_reg   <= 15'd0;
        end
        else
        begin
            header_sent_reg <= header_sent_next;
            byte_in_row_reg <= byte_in_row_next;
            row_index_reg   <= row_index_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/psbf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psbf_fifo: item queue between front and back
// Small register FIFO, head visible combinationally.
// ----------------------------------------------------------------------------
module psbf_fifo
    import psbf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire psbf_item_t wr_item,
    output      logic       full,
    output      logic       head_valid,
    output      psbf_item_t head,
    input  wire logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psbf_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/psbf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psbf_back: byte sequencer of the framer
// Walks each item's run one byte a cycle unless the output stalls, keeps CRC-32 and Adler-32.
// ----------------------------------------------------------------------------
module psbf_back
    import psbf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire psbf_item_t  head,
    output      logic        pop,
    input  wire logic [14:0] img_width,
    input  wire logic [14:0] img_height,
    output      logic        file_valid,
    input  wire logic        file_ready,
    output      logic [7:0]  file_byte,
    output      logic        run_last,
    output      logic        file_end
);

    function automatic logic [7:0] be_pick(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            2'd3: r = w[7:0];
        endcase
        return r;
    endfunction

    logic        busy_reg, busy_next;
    pos_t        pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] adler_lo_reg, adler_lo_next;
    logic [15:0] adler_hi_reg, adler_hi_next;
    logic [31:0] idat_len_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_end_reg;

    logic [15:0] row_len;
    logic [16:0] row_len_p5;
    logic [31:0] idat_prod;
    pos_t        cur_pos;
    pos_t        end_pos;
    logic        is_last;
    logic        load;
    logic [7:0]  byte_val;
    logic        crc_en;
    logic        crc_restart;
    logic        data_en;
    logic [31:0] crc_base;
    logic [16:0] lo_sum;
    logic [15:0] lo_mod;
    logic [16:0] hi_sum;
    logic [15:0] hi_mod;

    assign row_len    = {img_width, 1'b0} + {1'b0, img_width} + 16'd1;
    assign row_len_p5 = {1'b0, row_len} + 17'd5;
    assign idat_prod  = {15'd0, row_len_p5} * {17'd0, img_height};

    assign file_valid = out_valid_reg;
    assign file_byte  = out_byte_reg;
    assign run_last   = out_last_reg;
    assign file_end   = out_end_reg;

    always_comb
    begin
        if (busy_reg)
        begin
            cur_pos = pos_reg;
        end
        else if (head.hdr)
        begin
            cur_pos = POS_SIG;
        end
        else if (head.row_start)
        begin
            cur_pos = POS_BLK;
        end
        else
        begin
            cur_pos = POS_PIX;
        end
        end_pos = head.file_end ? POS_END : POS_PIX;
        is_last = cur_pos == end_pos;
        load    = head_valid && (!out_valid_reg || file_ready);
        pop     = load && is_last;
    end

    // byte of the current position
    always_comb
    begin
        byte_val = 8'd0;
        if (cur_pos < POS_IHDR_LEN)
        begin
            byte_val = PNG_SIG[8*(7 - 3'(cur_pos)) +: 8];
        end
        else if (cur_pos < POS_IHDR_TYPE)
        begin
            byte_val = be_pick(32'd13, 2'(cur_pos - POS_IHDR_LEN));
        end
        else if (cur_pos < POS_IMG_W)
        begin
            byte_val = be_pick(TYPE_IHDR, 2'(cur_pos - POS_IHDR_TYPE));
        end
        else if (cur_pos < POS_IMG_H)
        begin
            byte_val = be_pick({17'd0, img_width}, 2'(cur_pos - POS_IMG_W));
        end
        else if (cur_pos < POS_DEPTH)
        begin
            byte_val = be_pick({17'd0, img_height}, 2'(cur_pos - POS_IMG_H));
        end
        else if (cur_pos == POS_DEPTH)
        begin
            byte_val = BIT_DEPTH;
        end
        else if (cur_pos == POS_COLOR)
        begin
            byte_val = COLOR_RGB;
        end
        else if (cur_pos < POS_IHDR_CRC)
        begin
            byte_val = 8'd0;    // compression, filter, interlace
        end
        else if (cur_pos < POS_IDAT_LEN)
        begin
            byte_val = be_pick(~crc_reg, 2'(cur_pos - POS_IHDR_CRC));
        end
        else if (cur_pos < POS_IDAT_TYPE)
        begin
            byte_val = be_pick(idat_len_reg, 2'(cur_pos - POS_IDAT_LEN));
        end
        else if (cur_pos < POS_ZLIB)
        begin
            byte_val = be_pick(TYPE_IDAT, 2'(cur_pos - POS_IDAT_TYPE));
        end
        else if (cur_pos == POS_ZLIB)
        begin
            byte_val = ZLIB_CMF;
        end
        else if (cur_pos < POS_BLK)
        begin
            byte_val = ZLIB_FLG;
        end
        else if (cur_pos == POS_BLK)
        begin
            byte_val = {7'd0, head.last_row};
        end
        else if (cur_pos == POS_BLK + 7'd1)
        begin
            byte_val = row_len[7:0];
        end
        else if (cur_pos == POS_BLK + 7'd2)
        begin
            byte_val = row_len[15:8];
        end
        else if (cur_pos == POS_BLK + 7'd3)
        begin
            byte_val = ~row_len[7:0];
        end
        else if (cur_pos == POS_BLK + 7'd4)
        begin
            byte_val = ~row_len[15:8];
        end
        else if (cur_pos == POS_FILTER)
        begin
            byte_val = 8'd0;    // filter type None
        end
        else if (cur_pos == POS_PIX)
        begin
            byte_val = head.pix;
        end
        else if (cur_pos < POS_IDAT_CRC)
        begin
            byte_val = be_pick({adler_hi_reg, adler_lo_reg}, 2'(cur_pos - POS_ADLER));
        end
        else if (cur_pos < POS_IEND_LEN)
        begin
            byte_val = be_pick(~crc_reg, 2'(cur_pos - POS_IDAT_CRC));
        end
        else if (cur_pos < POS_IEND_TYPE)
        begin
            byte_val = 8'd0;
        end
        else if (cur_pos < POS_IEND_CRC)
        begin
            byte_val = be_pick(TYPE_IEND, 2'(cur_pos - POS_IEND_TYPE));
        end
        else
        begin
            byte_val = be_pick(~crc_reg, 2'(cur_pos - POS_IEND_CRC));
        end
    end

    // checksum bookkeeping
    always_comb
    begin
        crc_en = (cur_pos >= POS_IHDR_TYPE && cur_pos < POS_IHDR_CRC)
              || (cur_pos >= POS_IDAT_TYPE && cur_pos < POS_IDAT_CRC)
              || (cur_pos >= POS_IEND_TYPE && cur_pos < POS_IEND_CRC);
        crc_restart = cur_pos == POS_IHDR_TYPE || cur_pos == POS_IDAT_TYPE
                   || cur_pos == POS_IEND_TYPE;
        data_en  = cur_pos == POS_FILTER || cur_pos == POS_PIX;
        crc_base = crc_restart ? 32'hffffffff : crc_reg;

        lo_sum = {1'b0, adler_lo_reg} + {9'd0, byte_val};
        lo_mod = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
        hi_sum = {1'b0, adler_hi_reg} + {1'b0, lo_mod};
        hi_mod = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

        busy_next     = busy_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        adler_lo_next = adler_lo_reg;
        adler_hi_next = adler_hi_reg;
        if (load)
        begin
            busy_next = !is_last;
            pos_next  = cur_pos + 7'd1;
            if (crc_en)
            begin
                crc_next = crc_byte(crc_base, byte_val);
            end
            if (cur_pos == POS_SIG)
            begin
                adler_lo_next = 16'd1;
                adler_hi_next = 16'd0;
            end
            else if (data_en)
            begin
                adler_lo_next = lo_mod;
                adler_hi_next = hi_mod;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idat_len_reg <= idat_prod + 32'd6;
        if (load)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= is_last;
            out_end_reg  <= is_last && head.file_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_SIG;
            crc_reg       <= 32'hffffffff;
            adler_lo_reg  <= 16'd1;
            adler_hi_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            adler_lo_reg <= adler_lo_next;
            adler_hi_reg <= adler_hi_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (file_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/png_stored_block_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// Items are queued; the back end sends each run through its output register. Throughput:
// one file byte per cycle unless file_ready stalls it; a run is 1 byte mid-row, 7 at a
// row start, 50 on the first pixel of a file, plus 20 trailer bytes on the last pixel.
// Pixels are taken every cycle while the item queue has room; long runs fill the queue.
// Reset: control state and checksums clear at once, width and height read back as 1.
// ----------------------------------------------------------------------------
// png_stored_block_framer: PNG file writer with stored deflate blocks
// RGB bytes in, complete PNG byte stream out, APB configuration port.
// ----------------------------------------------------------------------------
module png_stored_block_framer
    import psbf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    // pixel bytes
    input  wire logic        pixel_valid,
    output      logic        pixel_ready,
    input  wire logic [7:0]  pixel_byte,
    // file bytes
    output      logic        file_valid,
    input  wire logic        file_ready,
    output      logic [7:0]  file_byte,
    output      logic        run_last,
    output      logic        file_end
);

    logic [14:0] image_width_reg;
    logic [14:0] image_height_reg;
    logic        cfg_write;

    // clamped view of the registers, used by both halves
    logic [14:0] img_width;
    logic [14:0] img_height;

    logic        push;
    logic        queue_full;
    logic        head_valid;
    logic        pop;
    psbf_item_t  wr_item;
    psbf_item_t  head;

    // ------------------------------------------------------------------
    // APB registers: always ready, paddr[2] picks width or height
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ADDR_HEIGHT[2]) ? {17'd0, image_height_reg}
                                                    : {17'd0, image_width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 15'd1;
            image_height_reg <= 15'd1;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ADDR_WIDTH[2])
            begin
                image_width_reg <= pwdata[14:0];
            end
            else
            begin
                image_height_reg <= pwdata[14:0];
            end
        end
    end

    // zero acts as one; width is also capped so a row fits a stored block
    assign img_width  = clamp_width(image_width_reg);
    assign img_height = clamp_height(image_height_reg);

    // ------------------------------------------------------------------
    // Front: accept and tag each pixel transaction with what goes around it
    // ------------------------------------------------------------------
    psbf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_byte  (pixel_byte),
        .img_width   (img_width),
        .img_height  (img_height),
        .queue_full  (queue_full),
        .push        (push),
        .item        (wr_item)
    );

    // ------------------------------------------------------------------
    // Queue: lets pixels keep flowing while the back end sends headers
    // ------------------------------------------------------------------
    psbf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_item    (wr_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // ------------------------------------------------------------------
    // Back: byte sequencer with CRC-32, Adler-32 and the output register
    // ------------------------------------------------------------------
    psbf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .img_width  (img_width),
        .img_height (img_height),
        .file_valid (file_valid),
        .file_ready (file_ready),
        .file_byte  (file_byte),
        .run_last   (run_last),
        .file_end   (file_end)
    );

endmodule
`default_nettype wire

FILE: rtl/core/psbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psbf_checker: port-level checks of the framer
// Output handshake and end-of-file framing, bound to the top level.
// ----------------------------------------------------------------------------
module psbf_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       file_valid,
    input wire logic       file_ready,
    input wire logic [7:0] file_byte,
    input wire logic       run_last,
    input wire logic       file_end
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        file_valid && !file_ready |=> file_valid)
        else $error("file_valid dropped before transaction");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        file_valid && !file_ready |=>
            $stable(file_byte) && $stable(run_last) && $stable(file_end))
        else $error("file payload changed while stalled");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        file_valid && file_end |-> run_last)
        else $error("file_end without run_last");

    // last byte of the IEND CRC is always 0x82
    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        file_valid && file_end |-> file_byte == 8'h82)
        else $error("file_end on a byte other than the IEND CRC tail");

    // a new file opens with a 50-byte run, so two ends cannot be adjacent
    a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
        file_valid && file_ready && file_end |=> !(file_valid && file_end))
        else $error("file_end on consecutive bytes");

endmodule

bind png_stored_block_framer psbf_checker u_psbf_checker (.*);
`default_nettype wire
